FILE: rtl/qsbs_pkg.sv
// qsbs_pkg: shared constants and sequencer state type of the quicksort buffer sorter.
// No dependencies.
`timescale 1ns / 1ps

package qsbs_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VALUE_W   = 32;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_POP,
		ST_RANGE,
		ST_X0,
		ST_X1,
		ST_X2,
		ST_X3,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SW0,
		ST_SW1,
		ST_FIN0,
		ST_FIN1,
		ST_FIN2,
		ST_PUSH_A,
		ST_PUSH_B,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} qsbs_state_t;

endpackage

FILE: rtl/quicksort_buffer_sorter_top.sv
// Loading takes items back to back; after the last item the sort runs partition by
// partition, bound by the single read port of the element store; then each result is
// read, registered and held until out_ready takes it, before the next is read.
// One set is handled at a time: no input is taken during sort and emission.
// Reset: arst_n clears the sequencer, element count, stack pointer, drop flag and out_valid; the RAMs are not cleared.
// quicksort_buffer_sorter_top: RAMs plus sequencer. Depends on qsbs_pkg, qsbs_ram, qsbs_ctrl.
`timescale 1ns / 1ps

module quicksort_buffer_sorter_top import qsbs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] sorted_value,
	output logic                      end_of_set,
	output logic                      overflow
);

	localparam int IW = $clog2(DEPTH);

	logic               store_we;
	logic [IW-1:0]      store_waddr, store_raddr;
	logic [VALUE_W-1:0] store_wdata, store_rdata;
	logic               stack_we;
	logic [IW-1:0]      stack_waddr, stack_raddr;
	logic [2*IW-1:0]    stack_wdata, stack_rdata;

	qsbs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(store_waddr),
		.wdata(store_wdata),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	qsbs_ram #(
		.WIDTH(2 * IW),
		.DEPTH(DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (stack_we),
		.waddr(stack_waddr),
		.wdata(stack_wdata),
		.raddr(stack_raddr),
		.rdata(stack_rdata)
	);

	qsbs_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sorted_value(sorted_value),
		.end_of_set  (end_of_set),
		.overflow    (overflow),
		.store_we    (store_we),
		.store_waddr (store_waddr),
		.store_wdata (store_wdata),
		.store_raddr (store_raddr),
		.store_rdata (store_rdata),
		.stack_we    (stack_we),
		.stack_waddr (stack_waddr),
		.stack_wdata (stack_wdata),
		.stack_raddr (stack_raddr),
		.stack_rdata (stack_rdata)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_item) |=> !in_ready)
		else $error("last item did not start the sort");

	a_end_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && end_of_set) |=> (in_ready && !out_valid))
		else $error("no return to loading after final result");

	a_no_store_write_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !store_we && !stack_we)
		else $error("store written during emission");

endmodule

FILE: rtl/qsbs_ram.sv
// qsbs_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module qsbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/qsbs_ctrl.sv
// qsbs_ctrl: load, partition/stack sequencer and emit logic of the quicksort sorter.
// Depends on qsbs_pkg; drives the element store and range stack RAM ports.
`timescale 1ns / 1ps

module qsbs_ctrl import qsbs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [VALUE_W-1:0]       value,
	input  logic                            last_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [VALUE_W-1:0]       sorted_value,
	output logic                            end_of_set,
	output logic                            overflow,
	output logic                            store_we,
	output logic [$clog2(DEPTH)-1:0]        store_waddr,
	output logic [VALUE_W-1:0]              store_wdata,
	output logic [$clog2(DEPTH)-1:0]        store_raddr,
	input  logic [VALUE_W-1:0]              store_rdata,
	output logic                            stack_we,
	output logic [$clog2(DEPTH)-1:0]        stack_waddr,
	output logic [2*$clog2(DEPTH)-1:0]      stack_wdata,
	output logic [$clog2(DEPTH)-1:0]        stack_raddr,
	input  logic [2*$clog2(DEPTH)-1:0]      stack_rdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qsbs_state_t state_q, state_d;

	logic [CW-1:0]      count_q, sp_q, k_q;
	logic               drop_q;
	logic [IW-1:0]      lo_q, hi_q, split_q;
	logic [VALUE_W-1:0] pivot_q, tmp_q;
	logic               push_l_q, push_r_q;
	logic               out_valid_q, end_q, ovf_q;
	logic [VALUE_W-1:0] out_value_q;

	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid;
	logic [IW-1:0] split_inc;
	logic          in_acc, full, is_less, k_past_hi, range_empty, emit_last;

	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[IW:1];
	assign split_inc   = split_q + IW'(1);
	assign in_acc      = in_valid && in_ready;
	assign full        = (count_q == CW'(DEPTH));
	assign is_less     = $signed(store_rdata) < $signed(pivot_q);
	assign k_past_hi   = k_q > CW'({1'b0, hi_q});
	assign range_empty = stack_rdata[IW-1:0] >= stack_rdata[2*IW-1:IW];
	assign emit_last   = (k_q + CW'(1)) == count_q;

	assign in_ready     = (state_q == ST_LOAD);
	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign end_of_set   = end_q;
	assign overflow     = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		store_we    = 1'b0;
		store_waddr = '0;
		store_wdata = '0;
		store_raddr = '0;
		stack_we    = 1'b0;
		stack_waddr = '0;
		stack_wdata = '0;
		stack_raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					store_we    = !full;
					store_waddr = count_q[IW-1:0];
					store_wdata = value;
					if (last_item) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				stack_we    = (count_q >= CW'(2));
				stack_waddr = '0;
				stack_wdata = {IW'(count_q - CW'(1)), IW'(0)};
				state_d     = ST_POP;
			end
			ST_POP: begin
				stack_raddr = IW'(sp_q - CW'(1));
				state_d     = (sp_q == '0) ? ST_EMIT_RD : ST_RANGE;
			end
			ST_RANGE: begin
				state_d = range_empty ? ST_POP : ST_X0;
			end
			ST_X0: begin
				store_raddr = lo_q;
				state_d     = ST_X1;
			end
			ST_X1: begin
				store_raddr = mid;
				state_d     = ST_X2;
			end
			ST_X2: begin
				store_we    = 1'b1;
				store_waddr = mid;
				store_wdata = tmp_q;
				state_d     = ST_X3;
			end
			ST_X3: begin
				store_we    = 1'b1;
				store_waddr = lo_q;
				store_wdata = pivot_q;
				state_d     = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				store_raddr = k_q[IW-1:0];
				state_d     = k_past_hi ? ST_FIN0 : ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				store_raddr = split_inc;
				state_d     = is_less ? ST_SW0 : ST_SCAN_RD;
			end
			ST_SW0: begin
				store_we    = 1'b1;
				store_waddr = k_q[IW-1:0];
				store_wdata = store_rdata;
				state_d     = ST_SW1;
			end
			ST_SW1: begin
				store_we    = 1'b1;
				store_waddr = split_q;
				store_wdata = tmp_q;
				state_d     = ST_SCAN_RD;
			end
			ST_FIN0: begin
				store_raddr = split_q;
				state_d     = ST_FIN1;
			end
			ST_FIN1: begin
				store_we    = 1'b1;
				store_waddr = lo_q;
				store_wdata = store_rdata;
				state_d     = ST_FIN2;
			end
			ST_FIN2: begin
				store_we    = 1'b1;
				store_waddr = split_q;
				store_wdata = pivot_q;
				state_d     = ST_PUSH_A;
			end
			ST_PUSH_A: begin
				stack_we    = push_l_q;
				stack_waddr = sp_q[IW-1:0];
				stack_wdata = {split_q - IW'(1), lo_q};
				state_d     = ST_PUSH_B;
			end
			ST_PUSH_B: begin
				stack_we    = push_r_q;
				stack_waddr = sp_q[IW-1:0];
				stack_wdata = {hi_q, split_inc};
				state_d     = ST_POP;
			end
			ST_EMIT_RD: begin
				store_raddr = k_q[IW-1:0];
				state_d     = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (out_ready) begin
					state_d = end_q ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sp_q        <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_INIT: begin
					sp_q <= (count_q >= CW'(2)) ? CW'(1) : CW'(0);
				end
				ST_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - CW'(1);
					end
				end
				ST_PUSH_A: begin
					if (push_l_q) begin
						sp_q <= sp_q + CW'(1);
					end
				end
				ST_PUSH_B: begin
					if (push_r_q) begin
						sp_q <= sp_q + CW'(1);
					end
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
				end
				ST_EMIT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (end_q) begin
							count_q <= '0;
							sp_q    <= '0;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_POP: begin
				k_q <= '0;
			end
			ST_RANGE: begin
				lo_q <= stack_rdata[IW-1:0];
				hi_q <= stack_rdata[2*IW-1:IW];
			end
			ST_X1: begin
				tmp_q <= store_rdata;
			end
			ST_X2: begin
				pivot_q <= store_rdata;
			end
			ST_X3: begin
				k_q     <= CW'({1'b0, lo_q}) + CW'(1);
				split_q <= lo_q;
			end
			ST_SCAN_CMP: begin
				if (is_less) begin
					tmp_q   <= store_rdata;
					split_q <= split_inc;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			ST_SW1: begin
				k_q <= k_q + CW'(1);
			end
			ST_FIN2: begin
				push_l_q <= CW'({1'b0, split_q}) > (CW'({1'b0, lo_q}) + CW'(1));
				push_r_q <= (CW'({1'b0, split_q}) + CW'(1)) < CW'({1'b0, hi_q});
			end
			ST_EMIT_LD: begin
				out_value_q <= store_rdata;
				end_q       <= emit_last;
				ovf_q       <= drop_q;
			end
			ST_EMIT_WAIT: begin
				if (out_ready) begin
					k_q <= k_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
